// ----- src/frti_pkg.sv -----
// ----------------------------------------------------------------------------
// frti_pkg: shared types and constants for the double round-to-integral block
// Rounding actions, IEEE-754 double field constants and the stage payload.
// ----------------------------------------------------------------------------
package frti_pkg;

    typedef enum logic [1:0] {
        ACT_FLOOR = 2'd0,
        ACT_CEIL  = 2'd1,
        ACT_TRUNC = 2'd2,
        ACT_NEAR  = 2'd3
    } action_t;

    localparam logic [10:0] EXP_MAX  = 11'h7FF;
    localparam logic [10:0] EXP_BIAS = 11'd1023;
    localparam logic [10:0] EXP_INT  = 11'd1075;
    localparam logic [63:0] ONE_BITS = 64'h3FF0_0000_0000_0000;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] operand;
    } stage_t;

endpackage

// ----- src/fp_round_to_integral.sv -----
// ----------------------------------------------------------------------------
// fp_round_to_integral: IEEE-754 double round to integral value
// Input register, one pass of rounding logic, result register.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_      | in        | s_action[1:0], s_operand_bits[63:0]
//  m_      | out       | m_result_bits[63:0]
//
// One beat per cycle sustained while m_ready stays high; m_valid rises once an
// accepted beat has moved from the input register into the result register,
// and a stalled result can hold the beat in the input register until then.
// Reset (aresetn low, synchronous) clears both valid bits.
// A stalled result holds the pipe; stages advance whenever downstream frees.
module fp_round_to_integral (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [63:0] s_operand_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_bits
);

    frti_pkg::stage_t in_reg;
    logic             in_valid_reg;
    logic [63:0]      res_reg;
    logic             res_valid_reg;
    logic [63:0]      res_next;
    logic             adv_out;
    logic             adv_in;

    assign adv_out = in_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv_out;
    assign adv_in  = s_valid && s_ready;

    frti_round u_round (
        .action  (in_reg.action),
        .operand (in_reg.operand),
        .result  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (adv_out) res_valid_reg <= 1'b1;
            else if (m_ready) res_valid_reg <= 1'b0;
        end
        if (adv_in) in_reg <= '{action: s_action, operand: s_operand_bits};
        if (adv_out) res_reg <= res_next;
    end

    assign m_valid       = res_valid_reg;
    assign m_result_bits = res_reg;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_bits))
        else $error("result dropped while stalled");
    a_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        adv_out |=> m_valid)
        else $error("advanced beat not shown");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("empty input stage not ready");
`endif

endmodule

// ----- src/frti_round.sv -----
// ----------------------------------------------------------------------------
// frti_round: combinational rounding of one double to an integral double
// Masks the fraction bits below the binary point and rounds per action.
// ----------------------------------------------------------------------------
module frti_round (
    input  logic [1:0]  action,
    input  logic [63:0] operand,
    output logic [63:0] result
);

    logic        neg;
    logic [10:0] e;
    logic [51:0] frac;
    logic [5:0]  f;
    logic [63:0] unit;
    logic [63:0] mask;
    logic [63:0] rem;
    logic [63:0] base;
    logic [63:0] half;
    logic        odd;
    logic        up;
    logic        up_small;

    always_comb begin
        neg  = operand[63];
        e    = operand[62:52];
        frac = operand[51:0];
        f    = 6'(frti_pkg::EXP_INT - e);
        unit = 64'd1 << f;
        mask = unit - 64'd1;
        rem  = operand & mask;
        base = operand & ~mask;
        half = unit >> 1;
        odd  = (f == 6'd52) ? 1'b1 : |(operand & unit);
        unique case (frti_pkg::action_t'(action))
            frti_pkg::ACT_FLOOR: begin up = neg;  up_small = neg;  end
            frti_pkg::ACT_CEIL:  begin up = !neg; up_small = !neg; end
            frti_pkg::ACT_TRUNC: begin up = 1'b0; up_small = 1'b0; end
            default: begin
                up       = (rem > half) || ((rem == half) && odd);
                up_small = (e == frti_pkg::EXP_BIAS - 11'd1) && (frac != 52'd0);
            end
        endcase
        if (e == frti_pkg::EXP_MAX || e >= frti_pkg::EXP_INT || operand[62:0] == 63'd0) begin
            result = operand;
        end else if (e < frti_pkg::EXP_BIAS) begin
            result = {neg, 63'd0} | (up_small ? frti_pkg::ONE_BITS : 64'd0);
        end else if (rem == 64'd0) begin
            result = operand;
        end else begin
            result = up ? base + unit : base;
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: randomized check of the double round-to-integral block
// Drives operands and rounding actions with random gaps, predicts each
// rounded value bit for bit and compares results in order of arrival.
// ----------------------------------------------------------------------------
module testbench;

    class round_scoreboard;
        logic [63:0] pending_q[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
        endtask

        // Bit-level rounding of one double under the given action.
        function logic [63:0] rounded(frti_pkg::action_t act, logic [63:0] x);
            logic        neg;
            logic [10:0] e;
            logic [51:0] frac;
            logic [63:0] unit, mask, rem, base, half;
            int          f;
            logic        up, odd;
            neg  = x[63];
            e    = x[62:52];
            frac = x[51:0];
            if (e == frti_pkg::EXP_MAX || e >= frti_pkg::EXP_INT || x[62:0] == 63'd0)
                return x;
            if (e < frti_pkg::EXP_BIAS) begin
                case (act)
                    frti_pkg::ACT_FLOOR: up = neg;
                    frti_pkg::ACT_CEIL:  up = !neg;
                    frti_pkg::ACT_TRUNC: up = 1'b0;
                    default: up = (e == frti_pkg::EXP_BIAS - 11'd1) && (frac != 52'd0);
                endcase
                return {neg, 63'd0} | (up ? frti_pkg::ONE_BITS : 64'd0);
            end
            f    = int'(frti_pkg::EXP_INT) - int'(e);
            unit = 64'd1 << f;
            mask = unit - 64'd1;
            rem  = x & mask;
            base = x & ~mask;
            if (rem == 64'd0)
                return x;
            case (act)
                frti_pkg::ACT_FLOOR: up = neg;
                frti_pkg::ACT_CEIL:  up = !neg;
                frti_pkg::ACT_TRUNC: up = 1'b0;
                default: begin
                    half = unit >> 1;
                    odd  = (f == 52) ? 1'b1 : x[f];
                    up   = (rem > half) || (rem == half && odd);
                end
            endcase
            return up ? base + unit : base;
        endfunction

        function void note_operand(frti_pkg::action_t act, logic [63:0] x);
            pending_q.push_back(rounded(act, x));
        endfunction

        task check_result(logic [63:0] got);
            logic [63:0] want;
            if (pending_q.size() == 0) begin
                report_mismatch("result with nothing pending", 64'd0, got);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want)
                report_mismatch("result_bits", want, got);
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [63:0] s_operand_bits;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_result_bits;

    round_scoreboard board;
    bit              calm;

    fp_round_to_integral uut (.*);

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    // Keep valid high across back-to-back beats; drop it only for a gap.
    task automatic send_beat(frti_pkg::action_t act, logic [63:0] x);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_operand_bits <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_operand(act, x);
    endtask

    function automatic logic [63:0] random_operand();
        logic [63:0] x;
        logic [10:0] e;
        x = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       e = 11'h7FF;
            1:       e = 11'd0;
            2:       e = 11'd1075 + 11'($urandom_range(0, 20));
            3:       e = 11'($urandom_range(1, 1022));
            default: e = 11'($urandom_range(1020, 1075));
        endcase
        x[62:52] = e;
        // sometimes land exactly on a half or an integer
        if ($urandom_range(0, 5) == 0 && e >= 11'd1023 && e < 11'd1075)
            x = (x & ~((64'd1 << (1075 - e)) - 1)) |
                ($urandom_range(0, 1) ? (64'd1 << (1074 - e)) : 64'd0);
        return x;
    endfunction

    // Result side: random stalls, checks every accepted beat.
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            board.check_result(m_result_bits);
        end
    end

    initial begin
        logic [63:0] edges[$];
        int          waited;
        board          = new();
        calm           = 1'b0;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_action       <= 2'd0;
        s_operand_bits <= 64'd0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        edges = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                  64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
                  64'h3FF8_0000_0000_0000, 64'h4004_0000_0000_0000,
                  64'h3FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                  64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0001,
                  64'h7FF8_0000_0000_0000, 64'h4330_0000_0000_0000,
                  64'h432F_FFFF_FFFF_FFFF, 64'hC32F_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'h3FE0_0000_0000_0001};
        foreach (edges[i])
            for (int a = 0; a < 4; a++)
                if (i < 6 || a == (i & 3))
                    send_beat(frti_pkg::action_t'(a), edges[i]);

        for (int n = 0; n < 1400; n++) begin
            // hold a run without gaps now and then
            if (n % 200 == 100) calm = 1'b1;
            if (n % 200 == 140) calm = 1'b0;
            send_beat(frti_pkg::action_t'($urandom_range(0, 3)), random_operand());
        end
        s_valid <= 1'b0;

        waited = 0;
        while (board.pending_q.size() != 0 && waited < 10000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (board.pending_q.size() != 0)
            board.report_mismatch("results missing", 64'd0, 64'(board.pending_q.size()));
        if (board.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
